// File: rtl/bls_pkg.sv
package bls_pkg;

  // storage geometry
  localparam int unsigned DEPTH   = 16;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);

  // field widths
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned OP_W     = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned CAP_W    = 5;

  // width used when comparing fill level against capacity
  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_PEEK    = 3'd2,
    OP_SEARCH  = 3'd3,
    OP_LIST_DN = 3'd4,
    OP_LIST_UP = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

endpackage

// File: rtl/bls_req_if.sv
interface bls_req_if;

  logic                                valid;
  logic                                ready;
  logic [bls_pkg::OP_W-1:0]            operation;
  logic signed [bls_pkg::DATA_W-1:0]   push_value;
  logic signed [bls_pkg::DATA_W-1:0]   search_key;

  modport source (output valid, output operation, output push_value, output search_key,
                  input ready);
  modport sink   (input valid, input operation, input push_value, input search_key,
                  output ready);

endinterface

// File: rtl/bls_rsp_if.sv
interface bls_rsp_if;

  logic                                valid;
  logic                                ready;
  logic [bls_pkg::STATUS_W-1:0]        status;
  logic signed [bls_pkg::DATA_W-1:0]   data_out;
  logic [bls_pkg::POS_W-1:0]           position;
  logic [bls_pkg::COUNT_W-1:0]         count;
  logic                                last;

  modport source (output valid, output status, output data_out, output position,
                  output count, output last, input ready);
  modport sink   (input valid, input status, input data_out, input position,
                  input count, input last, output ready);

endinterface

// File: rtl/bls_ram.sv
module bls_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/bounded_lifo_stack_with_search_core.sv
// Bounded LIFO stack of signed 32-bit words with search and listing.
// req_i carries one request (operation, push_value, search_key) and is
// taken when valid and ready are both high; ready is high only while the
// sequencer is idle. rsp_o returns results (status, data_out, position,
// count, last) under valid/ready; count is the fill level after the step.
// cfg_we_i/cfg_wdata_i write the capacity register; values above the
// stack depth act as the full depth, zero makes every push overflow.
// Push, overflow and empty cases register their result in the cycle
// after the request; pop and peek first pass through S_READ (one RAM
// read with registered data). A search reads one entry per cycle from the
// bottom until it finds a match or passes the top entry. A listing gives one
// result per entry, each read through S_READ after the previous one was taken,
// the final one flagged last. The next request is taken the cycle after
// the last result is taken, so requests never overlap.
// A stalled receiver holds the result register and the sequencer waits.
// Reset empties the stack, sets capacity to 16 and idles the sequencer;
// stored words are not cleared and are never read above the fill level.
module bounded_lifo_stack_with_search_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bls_pkg::CAP_W-1:0]     cfg_wdata_i,
  bls_req_if.sink                       req_i,
  bls_rsp_if.source                     rsp_o
);

  localparam int unsigned ADDR_W = bls_pkg::ADDR_W;
  localparam int unsigned CNT_W  = bls_pkg::CNT_W;
  localparam int unsigned CMP_W  = bls_pkg::CMP_W;
  localparam int unsigned DATA_W = bls_pkg::DATA_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]                 state_q, state_d;
  logic [CNT_W-1:0]           fill_q, fill_d;
  logic [bls_pkg::CAP_W-1:0]  cap_q, cap_d;
  bls_pkg::op_e               op_q, op_d;
  logic [DATA_W-1:0]          key_q, key_d;
  logic [ADDR_W-1:0]          idx_q, idx_d;
  bls_pkg::status_e           st_q, st_d;
  logic [DATA_W-1:0]          dat_q, dat_d;
  logic [ADDR_W-1:0]          pos_q, pos_d;
  logic                       last_q, last_d;

  logic                       ram_we;
  logic                       ram_re;
  logic [ADDR_W-1:0]          ram_raddr;
  logic [DATA_W-1:0]          ram_rdata;

  logic                       req_fire;
  logic                       rsp_fire;
  logic                       empty;
  logic                       full;
  logic [CMP_W-1:0]           cap_ext;
  logic [CMP_W-1:0]           eff_cap;
  logic [CNT_W-1:0]           fill_m1;
  logic [ADDR_W-1:0]          top_addr;
  logic [CNT_W-1:0]           idx_p1;
  logic                       at_top;

  // entry storage
  bls_ram #(
    .WIDTH (DATA_W),
    .DEPTH (bls_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q[ADDR_W-1:0]),
    .wdata_i (req_i.push_value),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // handshakes
  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign rsp_fire    = rsp_o.valid && rsp_o.ready;

  // fill level versus saturated capacity
  assign cap_ext  = CMP_W'(cap_q);
  assign eff_cap  = (cap_ext > CMP_W'(bls_pkg::DEPTH)) ? CMP_W'(bls_pkg::DEPTH) : cap_ext;
  assign full     = (CMP_W'(fill_q) >= eff_cap);
  assign empty    = (fill_q == '0);
  assign fill_m1  = fill_q - CNT_W'(1);
  assign top_addr = fill_m1[ADDR_W-1:0];
  assign idx_p1   = CNT_W'(idx_q) + CNT_W'(1);
  assign at_top   = (idx_p1 == fill_q);

  // sequencer
  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    cap_d     = cap_q;
    op_d      = op_q;
    key_d     = key_q;
    idx_d     = idx_q;
    st_d      = st_q;
    dat_d     = dat_q;
    pos_d     = pos_q;
    last_d    = last_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = idx_q;

    if (cfg_we_i) begin
      cap_d = cfg_wdata_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          op_d   = bls_pkg::op_e'(req_i.operation);
          key_d  = req_i.search_key;
          st_d   = bls_pkg::ST_OK;
          dat_d  = '0;
          pos_d  = '0;
          last_d = 1'b1;
          unique case (req_i.operation)
            bls_pkg::OP_PUSH: begin
              state_d = S_OUT;
              if (full) begin
                st_d = bls_pkg::ST_OVERFLOW;
              end else begin
                ram_we = 1'b1;
                dat_d  = req_i.push_value;
                pos_d  = fill_q[ADDR_W-1:0];
                fill_d = fill_q + CNT_W'(1);
              end
            end
            bls_pkg::OP_POP: begin
              if (empty) begin
                st_d    = bls_pkg::ST_EMPTY;
                state_d = S_OUT;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = top_addr;
                idx_d     = top_addr;
                fill_d    = fill_m1;
                state_d   = S_READ;
              end
            end
            bls_pkg::OP_PEEK: begin
              if (empty) begin
                st_d    = bls_pkg::ST_EMPTY;
                dat_d   = '1;
                state_d = S_OUT;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = top_addr;
                idx_d     = top_addr;
                state_d   = S_READ;
              end
            end
            bls_pkg::OP_SEARCH: begin
              if (empty) begin
                st_d    = bls_pkg::ST_NOTFOUND;
                state_d = S_OUT;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                idx_d     = '0;
                state_d   = S_READ;
              end
            end
            bls_pkg::OP_LIST_DN,
            bls_pkg::OP_LIST_UP: begin
              if (empty) begin
                st_d    = bls_pkg::ST_EMPTY;
                state_d = S_OUT;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = (req_i.operation == bls_pkg::OP_LIST_DN) ? top_addr : '0;
                idx_d     = ram_raddr;
                state_d   = S_READ;
              end
            end
            default: begin
              // unused codes: no result, no state change
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_READ: begin
        st_d    = bls_pkg::ST_OK;
        dat_d   = ram_rdata;
        pos_d   = idx_q;
        last_d  = 1'b1;
        state_d = S_OUT;
        unique case (op_q)
          bls_pkg::OP_SEARCH: begin
            if (ram_rdata == key_q) begin
              state_d = S_OUT;
            end else if (at_top) begin
              st_d  = bls_pkg::ST_NOTFOUND;
              dat_d = '0;
              pos_d = '0;
            end else begin
              // compare the next entry up
              ram_re    = 1'b1;
              ram_raddr = idx_q + ADDR_W'(1);
              idx_d     = ram_raddr;
              state_d   = S_READ;
            end
          end
          bls_pkg::OP_LIST_DN: last_d = (idx_q == '0);
          bls_pkg::OP_LIST_UP: last_d = at_top;
          default:             last_d = 1'b1;
        endcase
      end

      S_OUT: begin
        if (rsp_fire) begin
          if (last_q) begin
            state_d = S_IDLE;
          end else begin
            // fetch the next listed entry
            ram_re    = 1'b1;
            ram_raddr = (op_q == bls_pkg::OP_LIST_DN) ? (idx_q - ADDR_W'(1))
                                                      : (idx_q + ADDR_W'(1));
            idx_d     = ram_raddr;
            state_d   = S_READ;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      cap_q   <= bls_pkg::CAP_RESET;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      cap_q   <= cap_d;
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    key_q  <= key_d;
    idx_q  <= idx_d;
    st_q   <= st_d;
    dat_q  <= dat_d;
    pos_q  <= pos_d;
    last_q <= last_d;
  end

  // result channel
  assign rsp_o.valid    = (state_q == S_OUT);
  assign rsp_o.status   = st_q;
  assign rsp_o.data_out = dat_q;
  assign rsp_o.position = bls_pkg::POS_W'(pos_q);
  assign rsp_o.count    = bls_pkg::COUNT_W'(fill_q);
  assign rsp_o.last     = last_q;

endmodule

// File: bench/tb_bounded_lifo_stack_with_search_core.sv
module tb_bounded_lifo_stack_with_search_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH    = bls_pkg::DEPTH;
  localparam int unsigned DATA_W   = bls_pkg::DATA_W;
  localparam int unsigned OP_W     = bls_pkg::OP_W;
  localparam int unsigned STATUS_W = bls_pkg::STATUS_W;
  localparam int unsigned POS_W    = bls_pkg::POS_W;
  localparam int unsigned COUNT_W  = bls_pkg::COUNT_W;
  localparam int unsigned CAP_W    = bls_pkg::CAP_W;

  // opcodes the block ignores
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam int unsigned RANDOM_ITEMS    = 480;
  localparam int unsigned SETTLE_CYCLES   = 40;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam logic [DATA_W-1:0] PEEK_EMPTY_WORD = '1;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   data;
    logic [POS_W-1:0]    position;
    logic [COUNT_W-1:0]  count;
    logic                last;
  } stack_result_t;

  // shadow copy of the stack and the results it still owes
  class stack_tracker;
    logic [DATA_W-1:0] words [DEPTH];
    int unsigned       fill;
    logic [CAP_W-1:0]  capacity;
    stack_result_t     due_results [$];
    int unsigned       bad_results;

    function new();
      fill        = 0;
      capacity    = bls_pkg::CAP_RESET;
      bad_results = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] value);
      capacity = value;
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction

    function logic [DATA_W-1:0] held_word(int unsigned idx);
      return words[idx];
    endfunction

    function void owe(logic [STATUS_W-1:0] st, logic [DATA_W-1:0] word,
                      int unsigned idx, bit fin);
      stack_result_t r;
      r.status   = st;
      r.data     = word;
      r.position = POS_W'(idx);
      r.count    = COUNT_W'(fill);
      r.last     = fin;
      due_results.push_back(r);
    endfunction

    // work out the results of one accepted request
    function void take_request(logic [OP_W-1:0] op, logic [DATA_W-1:0] value,
                               logic [DATA_W-1:0] key);
      int unsigned limit;
      int unsigned at;
      bit          found;
      limit = (capacity > DEPTH) ? DEPTH : capacity;
      found = 0;
      case (op)
        bls_pkg::OP_PUSH: begin
          if (fill >= limit) begin
            owe(bls_pkg::ST_OVERFLOW, '0, 0, 1);
          end else begin
            words[fill] = value;
            fill++;
            owe(bls_pkg::ST_OK, value, fill - 1, 1);
          end
        end
        bls_pkg::OP_POP: begin
          if (fill == 0) begin
            owe(bls_pkg::ST_EMPTY, '0, 0, 1);
          end else begin
            fill--;
            owe(bls_pkg::ST_OK, words[fill], fill, 1);
          end
        end
        bls_pkg::OP_PEEK: begin
          if (fill == 0) owe(bls_pkg::ST_EMPTY, PEEK_EMPTY_WORD, 0, 1);
          else owe(bls_pkg::ST_OK, words[fill - 1], fill - 1, 1);
        end
        bls_pkg::OP_SEARCH: begin
          // first match from the bottom wins
          for (int unsigned i = 0; i < fill && !found; i++) begin
            if (words[i] == key) begin
              owe(bls_pkg::ST_OK, words[i], i, 1);
              found = 1;
            end
          end
          if (!found) owe(bls_pkg::ST_NOTFOUND, '0, 0, 1);
        end
        bls_pkg::OP_LIST_DN, bls_pkg::OP_LIST_UP: begin
          if (fill == 0) begin
            owe(bls_pkg::ST_EMPTY, '0, 0, 1);
          end else begin
            for (int unsigned i = 0; i < fill; i++) begin
              at = (op == bls_pkg::OP_LIST_DN) ? fill - 1 - i : i;
              owe(bls_pkg::ST_OK, words[at], at, i + 1 == fill);
            end
          end
        end
        default: ;
      endcase
    endfunction

    // compare one taken result against the oldest one owed
    function void check_result(stack_result_t got);
      stack_result_t want;
      if (due_results.size() == 0) begin
        bad_results++;
        $error("unexpected result: status %0d data %0h position %0d count %0d",
               got.status, got.data, got.position, got.count);
        return;
      end
      want = due_results.pop_front();
      if (got !== want) begin
        bad_results++;
        if (got.status !== want.status)
          $error("status mismatch: expected %0d, got %0d", want.status, got.status);
        if (got.data !== want.data)
          $error("data_out mismatch: expected %0h, got %0h", want.data, got.data);
        if (got.position !== want.position)
          $error("position mismatch: expected %0d, got %0d", want.position, got.position);
        if (got.count !== want.count)
          $error("count mismatch: expected %0d, got %0d", want.count, got.count);
        if (got.last !== want.last)
          $error("last mismatch: expected %0b, got %0b", want.last, got.last);
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CAP_W-1:0] cfg_wdata_i;

  bls_req_if req_if ();
  bls_rsp_if rsp_if ();

  stack_tracker tracker = new();
  bit           hold_off_req;
  int unsigned  burst_left;

  bounded_lifo_stack_with_search_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

  // receiver: changing stall patterns plus one long hold-off on demand
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned held;
    bit          take;
    mode_left = 0;
    held      = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      case (mode)
        0:       take = 1'b1;
        1:       take = $urandom_range(0, 1);
        2:       take = ($urandom_range(0, 3) != 0);
        default: take = ($urandom_range(0, 4) == 0);
      endcase
      if (hold_off_req) begin
        take = 1'b0;
        held++;
        if (held == HOLD_OFF_CYCLES) begin
          hold_off_req = 1'b0;
          held         = 0;
        end
      end
      rsp_if.ready <= take;
      @(posedge clk_i);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    stack_result_t got;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got.status   = rsp_if.status;
      got.data     = rsp_if.data_out;
      got.position = rsp_if.position;
      got.count    = rsp_if.count;
      got.last     = rsp_if.last;
      tracker.check_result(got);
    end
  end

  // offer one request, wait for it to be taken, then maybe pause
  task automatic send_request(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value,
                              input logic [DATA_W-1:0] key);
    int unsigned gap;
    req_if.valid      <= 1'b1;
    req_if.operation  <= op;
    req_if.push_value <= value;
    req_if.search_key <= key;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    tracker.take_request(op, value, key);
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end else begin
      burst_left--;
    end
  endtask

  // drain all owed results, then let a trailing ignored or search request finish
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_capacity(value);
  endtask

  // extremes, a small pool for repeats and matches, or anything
  function automatic logic [DATA_W-1:0] random_word();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return '0;
          default: return '1;
        endcase
      end
      1, 2:    return DATA_W'($urandom_range(0, 7)) - 32'd3;
      default: return $urandom();
    endcase
  endfunction

  // operation mix: 0 filling, 1 draining, 2 balanced
  function automatic logic [OP_W-1:0] pick_op(int unsigned style);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return ($urandom_range(0, 1) != 0) ? OP_SPARE_6 : OP_SPARE_7;
    case (style)
      0: begin
        if (r < 63) return bls_pkg::OP_PUSH;
        if (r < 73) return bls_pkg::OP_POP;
        if (r < 81) return bls_pkg::OP_PEEK;
        if (r < 91) return bls_pkg::OP_SEARCH;
      end
      1: begin
        if (r < 25) return bls_pkg::OP_PUSH;
        if (r < 60) return bls_pkg::OP_POP;
        if (r < 70) return bls_pkg::OP_PEEK;
        if (r < 85) return bls_pkg::OP_SEARCH;
      end
      default: begin
        if (r < 43) return bls_pkg::OP_PUSH;
        if (r < 63) return bls_pkg::OP_POP;
        if (r < 73) return bls_pkg::OP_PEEK;
        if (r < 87) return bls_pkg::OP_SEARCH;
      end
    endcase
    return ($urandom_range(0, 1) != 0) ? bls_pkg::OP_LIST_DN : bls_pkg::OP_LIST_UP;
  endfunction

  // stimulus
  initial begin
    int unsigned      sent;
    int unsigned      done_in_phase;
    int unsigned      phase_len;
    int unsigned      style;
    bit               pressed;
    logic [OP_W-1:0]  op;
    logic [DATA_W-1:0] key;
    logic [CAP_W-1:0] cap_choice;

    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_wdata_i       <= '0;
    req_if.valid      <= 1'b0;
    req_if.operation  <= bls_pkg::OP_PUSH;
    req_if.push_value <= '0;
    req_if.search_key <= '0;
    burst_left   = 0;
    hold_off_req = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty stack at the reset capacity, ignored opcodes
    send_request(bls_pkg::OP_POP, '0, '0);
    send_request(bls_pkg::OP_PEEK, '0, '0);
    send_request(bls_pkg::OP_SEARCH, '0, '0);
    send_request(bls_pkg::OP_LIST_DN, '0, '0);
    send_request(bls_pkg::OP_LIST_UP, '0, '0);
    send_request(OP_SPARE_6, '1, '1);
    send_request(OP_SPARE_7, '0, '0);

    // extreme words, duplicate search, listings both ways
    send_request(bls_pkg::OP_PUSH, 32'h7FFF_FFFF, '0);
    send_request(bls_pkg::OP_PUSH, 32'h8000_0000, '0);
    send_request(bls_pkg::OP_PUSH, '0, '0);
    send_request(bls_pkg::OP_PUSH, '1, '0);
    send_request(bls_pkg::OP_PUSH, 32'h8000_0000, '1);
    send_request(bls_pkg::OP_SEARCH, '0, 32'h8000_0000);
    send_request(bls_pkg::OP_SEARCH, '0, 32'h1234_5678);
    send_request(bls_pkg::OP_SEARCH, '0, '1);
    send_request(bls_pkg::OP_PEEK, '0, '0);
    send_request(bls_pkg::OP_LIST_DN, '0, '0);
    send_request(bls_pkg::OP_LIST_UP, '0, '0);
    send_request(bls_pkg::OP_POP, '0, '0);

    // capacity below the fill level, zero, and above the depth
    write_capacity(CAP_W'(1));
    send_request(bls_pkg::OP_PUSH, 32'h0000_0055, '0);
    send_request(bls_pkg::OP_LIST_DN, '0, '0);
    write_capacity(CAP_W'(0));
    send_request(bls_pkg::OP_PUSH, 32'hAAAA_AAAA, '0);
    write_capacity(CAP_W'(31));
    send_request(bls_pkg::OP_PUSH, 32'h5555_5555, '0);
    send_request(bls_pkg::OP_POP, '0, '0);

    // random phases, each under its own capacity
    sent    = 0;
    pressed = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      if (sent == 0) begin
        cap_choice = CAP_W'(16);
        style      = 0;
        phase_len  = 60;
      end else begin
        case ($urandom_range(0, 7))
          0:       cap_choice = CAP_W'(16);
          1:       cap_choice = CAP_W'(1);
          2:       cap_choice = CAP_W'(0);
          3:       cap_choice = CAP_W'(31);
          4:       cap_choice = CAP_W'(17);
          5:       cap_choice = CAP_W'(2);
          default: cap_choice = CAP_W'($urandom_range(0, 31));
        endcase
        style     = $urandom_range(0, 2);
        phase_len = $urandom_range(20, 60);
      end
      write_capacity(cap_choice);
      done_in_phase = 0;
      while (done_in_phase < phase_len && sent < RANDOM_ITEMS) begin
        op = pick_op(style);
        if (tracker.fill > 0 && $urandom_range(0, 1) != 0)
          key = tracker.held_word($urandom_range(0, tracker.fill - 1));
        else
          key = random_word();
        send_request(op, random_word(), key);
        if (op != OP_SPARE_6 && op != OP_SPARE_7) begin
          done_in_phase++;
          sent++;
        end
        // one long receiver hold-off while requests keep coming
        if (!pressed && sent >= 150) begin
          hold_off_req = 1'b1;
          pressed      = 1'b1;
        end
      end
    end

    wait_idle();
    if (tracker.bad_results == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
